// ----- src/cle_pkg.sv -----
// shared types, codes and constants for the cursor line edit buffer
// no dependencies; compiled first

package cle_pkg;

	localparam int DEF_BUF_DEPTH = 1024;

	// fixed field widths
	localparam int OP_W  = 2;
	localparam int KEY_W = 8;
	localparam int IDX_W = 10;
	localparam int OUT_W = 11;

	// operation codes
	localparam logic [OP_W-1:0] OP_KEY   = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	// editing keys
	localparam logic [KEY_W-1:0] KEY_HOME   = 8'h2D;
	localparam logic [KEY_W-1:0] KEY_END    = 8'h2B;
	localparam logic [KEY_W-1:0] KEY_RIGHT  = 8'h2A;
	localparam logic [KEY_W-1:0] KEY_DELETE = 8'h33;

	typedef enum logic [2:0] {
		KK_HOME,
		KK_END,
		KK_RIGHT,
		KK_DELETE,
		KK_INSERT
	} key_kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_RDWAIT,
		S_SHIFT,
		S_DRAIN,
		S_WKEY,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic clr_res;
		logic set_ovf;
		logic rd_idx;
		logic cap_rd;
		logic init_ins;
		logic init_del;
		logic step;
		logic drain;
		logic write_key;
		logic cur_home;
		logic cur_end;
		logic cur_right;
		logic len_dec;
		logic ins_commit;
		logic clear_line;
	} cle_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [OP_W-1:0] op;
		key_kind_t       key_kind;
		logic            full;
		logic            cur_at_end;
		logic            tail_one;
		logic            idx_in;
		logic            shift_last;
	} cle_stat_t;

	function automatic key_kind_t classify_key(input logic [KEY_W-1:0] k);
		key_kind_t kk;
		unique case (k)
			KEY_HOME:   kk = KK_HOME;
			KEY_END:    kk = KK_END;
			KEY_RIGHT:  kk = KK_RIGHT;
			KEY_DELETE: kk = KK_DELETE;
			default:    kk = KK_INSERT;
		endcase
		return kk;
	endfunction

endpackage

// ----- src/cle_ram.sv -----
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies

module cle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/cle_ctrl.sv -----
// controller state machine of the line edit buffer
// depends on cle_pkg

module cle_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  cle_pkg::cle_stat_t  stat,
	output cle_pkg::cle_cmd_t   cmd,
	output logic                busy,
	output logic                done
);

	import cle_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_DECODE;
			end
			S_DECODE: begin
				state_d = S_DONE;
				unique case (stat.op)
					OP_KEY: begin
						if (stat.key_kind == KK_DELETE) begin
							if (!stat.cur_at_end && !stat.tail_one) state_d = S_SHIFT;
						end else if (stat.key_kind == KK_INSERT && !stat.full) begin
							state_d = stat.cur_at_end ? S_WKEY : S_SHIFT;
						end
					end
					OP_READ: begin
						if (stat.idx_in) state_d = S_RDWAIT;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_RDWAIT: state_d = S_DONE;
			S_SHIFT: begin
				if (stat.shift_last) state_d = S_DRAIN;
			end
			S_DRAIN: state_d = (stat.key_kind == KK_DELETE) ? S_DONE : S_WKEY;
			S_WKEY:  state_d = S_DONE;
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd  = '0;
		busy = (state_q != S_IDLE);
		done = (state_q == S_DONE);
		unique case (state_q)
			S_IDLE: cmd.capture = start;
			S_DECODE: begin
				cmd.clr_res = 1'b1;
				unique case (stat.op)
					OP_KEY: begin
						unique case (stat.key_kind)
							KK_HOME:  cmd.cur_home = 1'b1;
							KK_END:   cmd.cur_end  = 1'b1;
							KK_RIGHT: cmd.cur_right = !stat.cur_at_end;
							KK_DELETE: begin
								if (!stat.cur_at_end) begin
									if (stat.tail_one) cmd.len_dec = 1'b1;
									else cmd.init_del = 1'b1;
								end
							end
							KK_INSERT: begin
								if (stat.full) cmd.set_ovf = 1'b1;
								else if (!stat.cur_at_end) cmd.init_ins = 1'b1;
							end
							default: cmd.clr_res = 1'b1;
						endcase
					end
					OP_READ:  cmd.rd_idx = stat.idx_in;
					OP_CLEAR: cmd.clear_line = 1'b1;
					default:  cmd.clr_res = 1'b1;
				endcase
			end
			S_RDWAIT: cmd.cap_rd = 1'b1;
			S_SHIFT:  cmd.step = 1'b1;
			S_DRAIN: begin
				cmd.drain   = 1'b1;
				cmd.len_dec = (stat.key_kind == KK_DELETE);
			end
			S_WKEY: begin
				cmd.write_key  = 1'b1;
				cmd.ins_commit = 1'b1;
			end
			S_DONE:  cmd = '0;
			default: cmd = '0;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_done_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("block still busy after result strobe");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done)) else $error("accepted item not taken up");
`endif

endmodule

// ----- src/cle_datapath.sv -----
// datapath: line store, length and cursor registers, shift pointers, results
// depends on cle_pkg and cle_ram

module cle_datapath #(
	parameter int BUF_DEPTH = cle_pkg::DEF_BUF_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [cle_pkg::OP_W-1:0]   operation,
	input  logic [cle_pkg::KEY_W-1:0]  key_char,
	input  logic [cle_pkg::IDX_W-1:0]  read_index,
	input  cle_pkg::cle_cmd_t          cmd,
	output cle_pkg::cle_stat_t         stat,
	output logic [cle_pkg::OUT_W-1:0]  line_length,
	output logic [cle_pkg::OUT_W-1:0]  cursor_pos,
	output logic [cle_pkg::KEY_W-1:0]  read_char,
	output logic                       overflow
);

	import cle_pkg::*;

	localparam int AW = $clog2(BUF_DEPTH);
	localparam int LW = $clog2(BUF_DEPTH + 1);
	localparam int CW = (LW > IDX_W) ? LW : IDX_W;

	logic [OP_W-1:0]  op_q;
	logic [KEY_W-1:0] key_q;
	logic [IDX_W-1:0] idx_q;
	logic [LW-1:0]    length_q;
	logic [LW-1:0]    cursor_q;
	logic [AW-1:0]    ptr_q;
	logic [AW-1:0]    wr_addr_q;
	logic             wr_pend_q;
	logic             dir_ins_q;
	logic [KEY_W-1:0] read_char_q;
	logic             ovf_q;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [KEY_W-1:0] ram_wdata;
	logic [AW-1:0]    ram_raddr;
	logic [KEY_W-1:0] ram_rdata;

	cle_ram #(
		.WIDTH(KEY_W),
		.DEPTH(BUF_DEPTH)
	) u_line_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// read at index for a read item, else at the shift pointer;
	// a shifted character is written in the cycle after its read
	always_comb begin
		ram_raddr = cmd.rd_idx ? AW'(idx_q) : ptr_q;
		ram_we    = (cmd.step && wr_pend_q) || cmd.drain || cmd.write_key;
		ram_waddr = cmd.write_key ? AW'(cursor_q) : wr_addr_q;
		ram_wdata = cmd.write_key ? key_q : ram_rdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q  <= '0;
			cursor_q  <= '0;
			wr_pend_q <= 1'b0;
		end else begin
			if (cmd.clear_line) begin
				length_q <= '0;
				cursor_q <= '0;
			end else if (cmd.cur_home) begin
				cursor_q <= '0;
			end else if (cmd.cur_end) begin
				cursor_q <= length_q;
			end else if (cmd.cur_right) begin
				cursor_q <= cursor_q + LW'(1);
			end else if (cmd.len_dec) begin
				length_q <= length_q - LW'(1);
			end else if (cmd.ins_commit) begin
				length_q <= length_q + LW'(1);
				cursor_q <= cursor_q + LW'(1);
			end
			if (cmd.init_ins || cmd.init_del) begin
				wr_pend_q <= 1'b0;
			end else if (cmd.step) begin
				wr_pend_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= operation;
			key_q <= key_char;
			idx_q <= read_index;
		end
		if (cmd.init_ins) begin
			ptr_q     <= AW'(length_q - LW'(1));
			dir_ins_q <= 1'b1;
		end else if (cmd.init_del) begin
			ptr_q     <= AW'(cursor_q + LW'(1));
			dir_ins_q <= 1'b0;
		end else if (cmd.step) begin
			wr_addr_q <= dir_ins_q ? ptr_q + AW'(1) : ptr_q - AW'(1);
			ptr_q     <= dir_ins_q ? ptr_q - AW'(1) : ptr_q + AW'(1);
		end
		if (cmd.cap_rd) begin
			read_char_q <= ram_rdata;
		end else if (cmd.clr_res) begin
			read_char_q <= '0;
		end
		if (cmd.set_ovf) begin
			ovf_q <= 1'b1;
		end else if (cmd.clr_res) begin
			ovf_q <= 1'b0;
		end
	end

	always_comb begin
		stat.op         = op_q;
		stat.key_kind   = classify_key(key_q);
		stat.full       = (length_q == LW'(BUF_DEPTH));
		stat.cur_at_end = (cursor_q == length_q);
		stat.tail_one   = ((LW+1)'(cursor_q) + (LW+1)'(1)) == (LW+1)'(length_q);
		stat.idx_in     = CW'(idx_q) < CW'(length_q);
		stat.shift_last = dir_ins_q ? (ptr_q == AW'(cursor_q))
			: (ptr_q == AW'(length_q - LW'(1)));
	end

	assign line_length = OUT_W'(length_q);
	assign cursor_pos  = OUT_W'(cursor_q);
	assign read_char   = read_char_q;
	assign overflow    = ovf_q;

`ifndef NO_ASSERTIONS
	a_cursor_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= length_q) else $error("cursor beyond end of line");
	a_length_bound: assert property (@(posedge clk) disable iff (!arst_n)
		length_q <= LW'(BUF_DEPTH)) else $error("line longer than store");
	a_shift_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && wr_pend_q) |-> (ram_waddr != ram_raddr))
		else $error("shift writes the entry it reads");
`endif

endmodule

// ----- src/cursor_line_edit_buffer.sv -----
// top level of the cursor line edit buffer: controller plus datapath
// depends on cle_pkg, cle_ctrl, cle_datapath (which holds cle_ram)
//
//  channel   handshake          payload
//  -------   ---------          -------
//  item in   start / busy       operation, key_char, read_index
//  result    done (one cycle)   line_length, cursor_pos, read_char, overflow
//
// an item is taken at an edge with start high and busy low; one result per item
// an insert away from the end of the line and a delete before the last character
// shift the characters from the cursor to the end, one store read and one store
// write per cycle on the single line store ram
// busy falls the cycle after the strobe
// reset clears length, cursor and controller; store contents stay undefined
// results cannot be stalled: done lasts exactly one cycle

module cursor_line_edit_buffer #(
	parameter int BUF_DEPTH = cle_pkg::DEF_BUF_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [cle_pkg::OP_W-1:0]   operation,
	input  logic [cle_pkg::KEY_W-1:0]  key_char,
	input  logic [cle_pkg::IDX_W-1:0]  read_index,
	output logic                       busy,
	output logic                       done,
	output logic [cle_pkg::OUT_W-1:0]  line_length,
	output logic [cle_pkg::OUT_W-1:0]  cursor_pos,
	output logic [cle_pkg::KEY_W-1:0]  read_char,
	output logic                       overflow
);

	import cle_pkg::*;

	// command and status bundles between controller and datapath
	cle_cmd_t  cmd;
	cle_stat_t stat;

	// sequencer: decode, read wait, shift loop, drain, final key write, result strobe
	cle_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	// line store, length/cursor registers and result registers
	cle_datapath #(
		.BUF_DEPTH(BUF_DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.operation  (operation),
		.key_char   (key_char),
		.read_index (read_index),
		.cmd        (cmd),
		.stat       (stat),
		.line_length(line_length),
		.cursor_pos (cursor_pos),
		.read_char  (read_char),
		.overflow   (overflow)
	);

endmodule

// ----- tb/cle_tb_pkg.sv -----
// scoreboard for the cursor line edit buffer: line predictor plus expected-result queue
// depends on cle_pkg for field widths, operation codes and editing keys

package cle_tb_pkg;

	import cle_pkg::*;

	localparam int LINE_DEPTH = DEF_BUF_DEPTH;
	localparam int SHOW_MAX   = 10;

	// operation code the block leaves unused
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [OUT_W-1:0] line_length;
		logic [OUT_W-1:0] cursor_pos;
		logic [KEY_W-1:0] read_char;
		logic             overflow;
	} edit_result_t;

	class line_scoreboard;
		logic [KEY_W-1:0] chars [LINE_DEPTH];
		int               line_len;
		int               cursor;
		edit_result_t     expected_q [$];
		int               errors;

		function new();
			line_len = 0;
			cursor   = 0;
			errors   = 0;
			foreach (chars[i]) chars[i] = '0;
		endfunction

		// apply one accepted item to the line and queue the result it should give
		function void note_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
				input logic [IDX_W-1:0] idx);
			edit_result_t r;
			int j;
			r = '0;
			case (op)
				OP_KEY: begin
					case (key)
						KEY_HOME:  cursor = 0;
						KEY_END:   cursor = line_len;
						KEY_RIGHT: if (cursor < line_len) cursor++;
						KEY_DELETE: begin
							if (cursor < line_len) begin
								for (j = cursor; j + 1 < line_len; j++) chars[j] = chars[j+1];
								line_len--;
							end
						end
						default: begin
							if (line_len >= LINE_DEPTH) begin
								r.overflow = 1'b1;
							end else begin
								for (j = line_len; j > cursor; j--) chars[j] = chars[j-1];
								chars[cursor] = key;
								cursor++;
								line_len++;
							end
						end
					endcase
				end
				OP_READ: if (idx < line_len) r.read_char = chars[idx];
				OP_CLEAR: begin
					line_len = 0;
					cursor   = 0;
				end
				default: ;
			endcase
			r.line_length = OUT_W'(line_len);
			r.cursor_pos  = OUT_W'(cursor);
			expected_q.push_back(r);
		endfunction

		function void check_result(input edit_result_t got);
			edit_result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= SHOW_MAX)
					$display("unexpected result: len %0d cur %0d char %02h ovf %0b",
						got.line_length, got.cursor_pos, got.read_char, got.overflow);
				return;
			end
			want = expected_q.pop_front();
			if (got.line_length !== want.line_length || got.cursor_pos !== want.cursor_pos ||
					got.read_char !== want.read_char || got.overflow !== want.overflow) begin
				errors++;
				if (errors <= SHOW_MAX)
					$display("mismatch: expected len %0d cur %0d char %02h ovf %0b,",
						want.line_length, want.cursor_pos, want.read_char, want.overflow,
						" got len %0d cur %0d char %02h ovf %0b",
						got.line_length, got.cursor_pos, got.read_char, got.overflow);
			end
		endfunction
	endclass

endpackage

// ----- tb/tb_top.sv -----
// self-checking bench for cursor_line_edit_buffer: directed edits, random editing, long line
// depends on cle_pkg, cle_tb_pkg and the block's RTL

module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import cle_pkg::*;
	import cle_tb_pkg::*;

	localparam int RANDOM_ITEMS = 300;
	localparam int LONG_LINE = 220;
	localparam int LONG_EDITS = 30;
	// longest quiet stretch is an insert at home on a nearly full line plus the longest
	// sender gap, so this leaves several times the margin
	localparam int QUIET_LIMIT = 6000;
	localparam int TAIL_CYCLES = 40;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [OP_W-1:0]   operation = OP_KEY;
	logic [KEY_W-1:0]  key_char = '0;
	logic [IDX_W-1:0]  read_index = '0;
	logic              busy;
	logic              done;
	logic [OUT_W-1:0]  line_length;
	logic [OUT_W-1:0]  cursor_pos;
	logic [KEY_W-1:0]  read_char;
	logic              overflow;

	line_scoreboard sb;
	int             burst_left = 0;
	int             quiet = 0;

	cursor_line_edit_buffer #(
		.BUF_DEPTH(LINE_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.operation(operation),
		.key_char(key_char),
		.read_index(read_index),
		.busy(busy),
		.done(done),
		.line_length(line_length),
		.cursor_pos(cursor_pos),
		.read_char(read_char),
		.overflow(overflow)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// monitor: results are checked before the item taken at the same edge is noted
	always @(posedge clk) begin : monitor
		edit_result_t got;
		if (arst_n) begin
			if (done === 1'b1) begin
				got.line_length = line_length;
				got.cursor_pos  = cursor_pos;
				got.read_char   = read_char;
				got.overflow    = overflow;
				sb.check_result(got);
			end
			if (start === 1'b1 && busy === 1'b0)
				sb.note_item(operation, key_char, read_index);
			// watchdog: any accepted item or result counts as progress
			if (done === 1'b1 || (start === 1'b1 && busy === 1'b0))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// present one item at the falling edge and hold it until the block takes it
	task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
			input logic [IDX_W-1:0] idx);
		@(negedge clk);
		start      <= 1'b1;
		operation  <= op;
		key_char   <= key;
		read_index <= idx;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// sender idle cycles; the payload wiggles while start is low
	task automatic hold_off(input int n);
		repeat (n) begin
			@(negedge clk);
			start      <= 1'b0;
			operation  <= OP_W'($urandom);
			key_char   <= KEY_W'($urandom);
			read_index <= IDX_W'($urandom);
		end
	endtask

	// random spacing: mostly back to back or short, a few long, with gap-free bursts
	task automatic pace();
		int r;
		int n;
		r = $urandom_range(0, 99);
		n = 0;
		if (burst_left > 0)
			burst_left--;
		else if (r < 5)
			burst_left = $urandom_range(10, 40);
		else if (r < 50)
			n = 0;
		else if (r < 85)
			n = $urandom_range(1, 3);
		else if (r < 97)
			n = $urandom_range(4, 12);
		else
			n = $urandom_range(20, 80);
		hold_off(n);
	endtask

	// stop sending until every queued result has come back
	task automatic wait_drained();
		hold_off(1);
		while (sb.expected_q.size() != 0) @(negedge clk);
	endtask

	// a printable-or-not byte that is inserted rather than treated as an editing key
	function automatic logic [KEY_W-1:0] typed_char();
		logic [KEY_W-1:0] k;
		do k = KEY_W'($urandom);
		while (k == KEY_HOME || k == KEY_END || k == KEY_RIGHT || k == KEY_DELETE);
		return k;
	endfunction

	// one random edit; inserts dominate so lines grow, reads mostly land inside the line
	task automatic random_edit();
		int r;
		logic [KEY_W-1:0] k;
		logic [IDX_W-1:0] ix;
		r  = $urandom_range(0, 99);
		k  = KEY_W'($urandom);
		ix = IDX_W'($urandom_range(0, sb.line_len + 3));
		if ($urandom_range(0, 3) == 0) ix = IDX_W'($urandom);
		if (r < 45)
			send_item(OP_KEY, k, ix);
		else if (r < 53)
			send_item(OP_KEY, KEY_HOME, ix);
		else if (r < 61)
			send_item(OP_KEY, KEY_END, ix);
		else if (r < 71)
			send_item(OP_KEY, KEY_RIGHT, ix);
		else if (r < 81)
			send_item(OP_KEY, KEY_DELETE, ix);
		else if (r < 94)
			send_item(OP_READ, k, ix);
		else if (r < 97)
			send_item(OP_CLEAR, k, ix);
		else
			send_item(OP_UNUSED, k, ix);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty line corner cases
		send_item(OP_READ, 8'h00, '0);            // read past length on an empty line
		send_item(OP_KEY, KEY_DELETE, '0);        // delete with cursor at end
		send_item(OP_KEY, KEY_RIGHT, '0);         // cursor right at end
		send_item(OP_KEY, 8'h00, '0);             // nul is an ordinary character
		send_item(OP_KEY, 8'hFF, {IDX_W{1'b1}});
		send_item(OP_KEY, 8'h41, '0);
		pace();
		send_item(OP_KEY, KEY_HOME, '0);
		send_item(OP_KEY, 8'h7E, '0);             // insert at home shifts the whole tail
		send_item(OP_KEY, KEY_RIGHT, '0);
		send_item(OP_KEY, KEY_DELETE, '0);        // delete in the middle
		send_item(OP_READ, 8'h00, 10'd0);
		send_item(OP_READ, 8'h00, 10'd1);
		send_item(OP_READ, 8'h00, 10'd2);
		pace();
		send_item(OP_KEY, KEY_END, '0);
		send_item(OP_KEY, KEY_DELETE, '0);        // delete at end is a no-op
		send_item(OP_KEY, KEY_RIGHT, '0);         // right at end is a no-op
		send_item(OP_READ, 8'h00, {IDX_W{1'b1}}); // far past length
		send_item(OP_UNUSED, 8'hFF, {IDX_W{1'b1}});
		send_item(OP_CLEAR, 8'hFF, '0);
		send_item(OP_READ, 8'h00, 10'd0);         // old contents are gone after clear
		send_item(OP_KEY, 8'h20, '0);
		wait_drained();

		// random editing on short lines, with two full pauses
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			random_edit();
			pace();
			if (n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3) wait_drained();
		end

		// build a long line by typing at the end, then edit near both ends
		send_item(OP_CLEAR, 8'h00, '0);
		for (int n = 0; n < LONG_LINE; n++) begin
			send_item(OP_KEY, typed_char(), IDX_W'($urandom));
			pace();
			if (n == LONG_LINE / 2) wait_drained();
		end
		send_item(OP_READ, 8'h00, IDX_W'(LONG_LINE - 1)); // last stored character
		send_item(OP_READ, 8'h00, '0);
		send_item(OP_KEY, KEY_HOME, '0);
		send_item(OP_KEY, typed_char(), '0);       // long right shift
		send_item(OP_KEY, KEY_RIGHT, '0);
		send_item(OP_KEY, KEY_DELETE, '0);         // long left shift
		send_item(OP_KEY, KEY_END, '0);
		send_item(OP_KEY, KEY_DELETE, '0);
		send_item(OP_KEY, KEY_RIGHT, '0);
		for (int n = 0; n < LONG_EDITS; n++) begin
			random_edit();
			pace();
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
